@@ rtl/vector3_normalize_assert.svh @@
// Assertion macros for the vector normalizer.
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define VN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define VN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define VN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/vn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;
    localparam int COMP_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int THR_WIDTH      = 16;
    typedef logic [THR_WIDTH-1:0] t_thr;
    localparam t_thr THR_RESET    = t_thr'(1);
endpackage
`default_nettype wire

@@ rtl/vn_square.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Magnitudes and sum of squares, four stages.
module vn_square import vn_pkg::*; #(
    parameter int W = COMP_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic [3:0]       i_en,
    input  logic [3*W-1:0]   i_comp,
    output logic [2*W-1:0]   o_sum,
    output logic [3*W-1:0]   o_mag,
    output logic [2:0]       o_neg
);
    localparam int L  = (W + 1) / 2;
    localparam int HW = W - L;

    logic [W-1:0]   r_mag0 [3];
    logic [W-1:0]   r_mag1 [3];
    logic [W-1:0]   r_mag2 [3];
    logic [W-1:0]   r_mag3 [3];
    logic [2:0]     r_neg0, r_neg1, r_neg2, r_neg3;
    logic [2*L-1:0] r_ll [3];
    logic [2*HW-1:0] r_hh [3];
    logic [W-1:0]   r_hl [3];
    logic [2*W-1:0] r_sq [3];
    logic [2*W-1:0] r_sum;

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_comp
            logic [W-1:0] comp;
            logic [W-1:0] mag;
            assign comp = i_comp[c*W +: W];
            // exact magnitude, most negative value included
            assign mag  = comp[W-1] ? (~comp + 1'b1) : comp;

            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_mag0[c] <= mag;
                    r_neg0[c] <= comp[W-1];
                end
                // partial products of the two halves
                if (i_en[1]) begin
                    r_ll[c]   <= r_mag0[c][L-1:0] * r_mag0[c][L-1:0];
                    r_hh[c]   <= r_mag0[c][W-1:L] * r_mag0[c][W-1:L];
                    r_hl[c]   <= r_mag0[c][W-1:L] * r_mag0[c][L-1:0];
                    r_mag1[c] <= r_mag0[c];
                    r_neg1[c] <= r_neg0[c];
                end
                // recombine to one square
                if (i_en[2]) begin
                    r_sq[c]   <= {r_hh[c], {(2*L){1'b0}}}
                               + {{(HW-1){1'b0}}, r_hl[c], {(L+1){1'b0}}}
                               + {{(2*W-2*L){1'b0}}, r_ll[c]};
                    r_mag2[c] <= r_mag1[c];
                    r_neg2[c] <= r_neg1[c];
                end
                if (i_en[3]) begin
                    r_mag3[c] <= r_mag2[c];
                    r_neg3[c] <= r_neg2[c];
                end
            end
            assign o_mag[c*W +: W] = r_mag3[c];
        end
    endgenerate

    // sum of the three squares
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_sum = r_sum;
    assign o_neg = r_neg3;
endmodule
`default_nettype wire

@@ rtl/vn_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Integer square root, one root bit per stage, with side data carried along.
module vn_sqrt import vn_pkg::*; #(
    parameter int W  = COMP_WIDTH_DEF,
    parameter int SB = 3 * COMP_WIDTH_DEF + 3
) (
    input  logic            i_clk,
    input  logic [W-1:0]    i_en,
    input  logic [2*W-1:0]  i_rad,
    input  logic [SB-1:0]   i_sb,
    output logic [W-1:0]    o_root,
    output logic [SB-1:0]   o_sb
);
    logic [2*W-1:0] r_rem  [W];
    logic [W-1:0]   r_root [W];
    logic [SB-1:0]  r_sb   [W];
    logic [2*W-1:0] rem_in  [W];
    logic [W-1:0]   root_in [W];
    logic [SB-1:0]  sb_in   [W];

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_bit
            localparam int B = W - 1 - k;
            logic [2*W:0] trial;
            logic         take;
            if (k == 0) begin : g_first
                assign rem_in[k]  = i_rad;
                assign root_in[k] = '0;
                assign sb_in[k]   = i_sb;
            end else begin : g_next
                assign rem_in[k]  = r_rem[k-1];
                assign root_in[k] = r_root[k-1];
                assign sb_in[k]   = r_sb[k-1];
            end
            // (r + 2^B)^2 - r^2
            assign trial = ({{(W+1){1'b0}}, root_in[k]} << (B + 1))
                         | ((2*W+1)'(1) << (2 * B));
            assign take  = {1'b0, rem_in[k]} >= trial;

            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k]  <= take ? (rem_in[k] - trial[2*W-1:0]) : rem_in[k];
                    r_root[k] <= take ? (root_in[k] | (W'(1) << B)) : root_in[k];
                    r_sb[k]   <= sb_in[k];
                end
            end
        end
    endgenerate

    assign o_root = r_root[W-1];
    assign o_sb   = r_sb[W-1];
endmodule
`default_nettype wire

@@ rtl/vn_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Threshold check, scaled quotient per component (one bit per stage), sign and clamp.
module vn_div import vn_pkg::*; #(
    parameter int W = COMP_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic [F+1:0]        i_en,
    input  logic [W-1:0]        i_len,
    input  t_thr                i_thr,
    input  logic [3*W-1:0]      i_mag,
    input  logic [2:0]          i_neg,
    output logic [3*(F+2)-1:0]  o_norm,
    output logic                o_ok
);
    localparam int CW = (W > THR_WIDTH) ? W : THR_WIDTH;
    localparam int OW = F + 2;

    logic [W-1:0] r_len [F+1];
    logic         r_deg [F+1];
    logic         r_ok;
    logic         deg;

    assign deg = (i_len == '0) || (CW'(i_len) < CW'(i_thr));

    genvar j;
    generate
        for (j = 0; j <= F; j++) begin : g_ctl
            if (j == 0) begin : g_head
                always_ff @(posedge i_clk) begin
                    if (i_en[0]) begin
                        r_len[0] <= i_len;
                        r_deg[0] <= deg;
                    end
                end
            end else begin : g_tail
                always_ff @(posedge i_clk) begin
                    if (i_en[j]) begin
                        r_len[j] <= r_len[j-1];
                        r_deg[j] <= r_deg[j-1];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en[F+1]) begin
            r_ok <= !r_deg[F];
        end
    end

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_comp
            logic [W-1:0]  r_rem [F+1];
            logic [F-1:0]  r_q   [F+1];
            logic          r_sat [F+1];
            logic          r_neg [F+1];
            logic [OW-1:0] r_out;
            logic [F:0]    qmag;
            logic [OW-1:0] sval;
            logic [W-1:0]  mag;

            assign mag = i_mag[c*W +: W];

            // setup: saturate when the component reaches the length
            always_ff @(posedge i_clk) begin
                if (i_en[0]) begin
                    r_rem[0] <= mag;
                    r_q[0]   <= '0;
                    r_sat[0] <= mag >= i_len;
                    r_neg[0] <= i_neg[c];
                end
            end

            // restoring division, one quotient bit per stage
            for (j = 1; j <= F; j++) begin : g_it
                logic [W:0] rem2;
                logic       ge;
                assign rem2 = {r_rem[j-1], 1'b0};
                assign ge   = rem2 >= {1'b0, r_len[j-1]};
                always_ff @(posedge i_clk) begin
                    if (i_en[j]) begin
                        r_rem[j] <= ge ? W'(rem2 - {1'b0, r_len[j-1]}) : rem2[W-1:0];
                        r_q[j]   <= {r_q[j-1][F-2:0], ge};
                        r_sat[j] <= r_sat[j-1];
                        r_neg[j] <= r_neg[j-1];
                    end
                end
            end

            // clamp, sign, zero for a degenerate vector
            assign qmag = r_sat[F] ? ((F+1)'(1) << F) : {1'b0, r_q[F]};
            assign sval = r_neg[F] ? (~{1'b0, qmag} + 1'b1) : {1'b0, qmag};
            always_ff @(posedge i_clk) begin
                if (i_en[F+1]) begin
                    r_out <= r_deg[F] ? '0 : sval;
                end
            end
            assign o_norm[c*OW +: OW] = r_out;
        end
    endgenerate

    assign o_ok = r_ok;
endmodule
`default_nettype wire

@@ rtl/vector3_normalize.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload (lowest bits first)
// s_axis    in         tdata: in_x, in_y, in_z (COMP_WIDTH each), zero pad to bytes
// m_axis    out        tdata: norm_x, norm_y, norm_z (FRAC_BITS+2 each), pad; tuser: ok
// cfg       in         i_cfg_data: zero_threshold (16 bits)
//
// The pipeline has four stages of squares and sum, one stage per root bit, a check
// stage, one stage per quotient bit and an output stage. One word is taken per cycle
// while the output is not stalled.
// Each stage advances whenever it is empty or the stage after it moves, so
// bubbles close up and words keep entering while a result waits at the output, until every stage is full.
// Reset is synchronous, active low; it clears the valid bits and sets the threshold to 1.
module vector3_normalize import vn_pkg::*; #(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0]          s_axis_tdata,  // in_x, in_y, in_z
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    output logic [((3*(FRAC_BITS+2)+7)/8)*8-1:0]       m_axis_tdata,  // norm_x, norm_y, norm_z
    output logic [0:0]                                 m_axis_tuser,  // ok
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  t_thr                                       i_cfg_data
);
    localparam int W   = COMP_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int OW  = F + 2;
    localparam int N   = W + F + 6;
    localparam int SB  = 3 * W + 3;
    localparam int OTW = ((3*OW+7)/8)*8;

    logic [N-1:0]     r_vld;
    logic [N:0]       rdy;
    t_thr             r_thr;
    logic [2*W-1:0]   sum;
    logic [3*W-1:0]   mag_sq, mag_rt;
    logic [2:0]       neg_sq, neg_rt;
    logic [W-1:0]     len;
    logic [3*OW-1:0]  norm;
    logic             ok;
    logic signed [OW-1:0] w_nx, w_ny, w_nz;
    logic             w_unit;
    localparam logic signed [OW-1:0] ONE = OW'(1) << F;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // stage flow control: a stage loads when empty or its successor moves
    assign rdy[N] = m_axis_tready;
    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_flow
            assign rdy[k] = !r_vld[k] || rdy[k+1];
            if (k == 0) begin : g_head
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[0] <= 1'b0;
                    end else if (rdy[0]) begin
                        r_vld[0] <= s_axis_tvalid;
                    end
                end
            end else begin : g_tail
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld[k] <= 1'b0;
                    end else if (rdy[k]) begin
                        r_vld[k] <= r_vld[k-1];
                    end
                end
            end
        end
    endgenerate

    vn_square #(.W(W)) u_square (
        .i_clk  (i_clk),
        .i_en   (rdy[3:0]),
        .i_comp (s_axis_tdata[3*W-1:0]),
        .o_sum  (sum),
        .o_mag  (mag_sq),
        .o_neg  (neg_sq)
    );

    vn_sqrt #(.W(W), .SB(SB)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (rdy[4+W-1:4]),
        .i_rad  (sum),
        .i_sb   ({neg_sq, mag_sq}),
        .o_root (len),
        .o_sb   ({neg_rt, mag_rt})
    );

    vn_div #(.W(W), .F(F)) u_div (
        .i_clk  (i_clk),
        .i_en   (rdy[N-1:4+W]),
        .i_len  (len),
        .i_thr  (r_thr),
        .i_mag  (mag_rt),
        .i_neg  (neg_rt),
        .o_norm (norm),
        .o_ok   (ok)
    );

    assign s_axis_tready   = rdy[0];
    assign m_axis_tvalid   = r_vld[N-1];
    assign m_axis_tdata    = OTW'(norm);
    assign m_axis_tuser[0] = ok;

    assign w_nx = norm[0 +: OW];
    assign w_ny = norm[OW +: OW];
    assign w_nz = norm[2*OW +: OW];

    // every component within plus or minus one
    assign w_unit = (w_nx <= ONE) && (w_nx >= -ONE) && (w_ny <= ONE) && (w_ny >= -ONE)
                 && (w_nz <= ONE) && (w_nz >= -ONE);

`include "vector3_normalize_assert.svh"

    `VN_ASSERT_IMP(a_deg_zero, i_clk, i_rst_n, m_axis_tvalid && !ok, norm == '0, "degenerate not zero")
    `VN_ASSERT_IMP(a_ok_range, i_clk, i_rst_n, m_axis_tvalid && ok, w_unit, "value beyond unit")
    `VN_ASSERT_NXT(a_thr_hold, i_clk, i_rst_n, !i_cfg_valid, r_thr == $past(r_thr), "threshold changed")
endmodule
`default_nettype wire
